@@ sv/orthogonal_lasso_soft_threshold_unit_defines.svh @@
// assertion macros used by the lasso soft threshold back end (olst_back)
// no dependencies; every user must have clk_i and rst_ni in scope
`ifndef ORTHOGONAL_LASSO_SOFT_THRESHOLD_UNIT_DEFINES_SVH
`define ORTHOGONAL_LASSO_SOFT_THRESHOLD_UNIT_DEFINES_SVH

// plain property check, disabled during reset
`define OLST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define OLST_ASSERT_IMP(lbl, ante, cons, msg) \
  `OLST_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define OLST_ASSERT_NXT(lbl, ante, cons, msg) \
  `OLST_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ sv/olst_pkg.sv @@
// package for the lasso soft threshold unit: constants, codes and types
// no dependencies
package olst_pkg;

  localparam int MaxColumns = 64;
  localparam int MaxRows    = 65536;
  localparam int ColW       = 6;
  localparam int DataW      = 32;
  localparam int RowW       = 17;
  localparam int CntW       = 7;
  localparam int FifoDepth  = 4;

  typedef enum logic [1:0] {
    OP_ACC = 2'd0,
    OP_EIG = 2'd1,
    OP_FIN = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_LAMBDA = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_COLS   = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_RD,
    ST_LOAD,
    ST_SQRT,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_CMP,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } bk_state_e;

  typedef struct packed {
    op_e                   op;
    logic [ColW-1:0]       col;
    logic [2*DataW-1:0]    data;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0] lambda;
    logic [RowW-1:0]  row_count;
    logic [CntW-1:0]  column_count;
  } cfg_t;

endpackage

@@ sv/orthogonal_lasso_soft_threshold_unit.sv @@
// lasso soft threshold unit, top level: config registers, front and back
// depends on olst_pkg, olst_front, olst_back, olst_ram
// element requests wait in a 4-entry fifo; an accumulate also passes ST_ACC
// finish: per column a 24-step square root, then an 88-step divide where needed
// results leave through an output register
// asynchronous active-low reset clears control state and accumulators
module orthogonal_lasso_soft_threshold_unit import olst_pkg::*; #(
  parameter int MAX_COLUMNS = MaxColumns
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,  // col_index, u_value, y_value, d_value
  input  logic [1:0]    s_axis_tuser,  // req_type
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [39:0]   m_axis_tdata,  // col_index_out, beta
  output logic          m_axis_tlast,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);

  cfg_t            cfg_q;
  logic            head_vld, pop;
  cmd_t            head;
  logic [ColW-1:0] ocol;
  logic [DataW-1:0] obeta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lambda       <= '0;
      cfg_q.row_count    <= RowW'(1);
      cfg_q.column_count <= CntW'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LAMBDA: cfg_q.lambda       <= cfg_wdata_i;
        CFG_ROWS:   cfg_q.row_count    <= cfg_wdata_i[RowW-1:0];
        CFG_COLS:   cfg_q.column_count <= cfg_wdata_i[CntW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  olst_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s_axis_tvalid),
    .in_rdy_o   (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .col_i      (s_axis_tdata[5:0]),
    .u_i        (s_axis_tdata[37:6]),
    .y_i        (s_axis_tdata[69:38]),
    .d_i        (s_axis_tdata[101:70]),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  olst_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_vld_i (head_vld),
    .head_i     (head),
    .pop_o      (pop),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_col_o  (ocol),
    .out_beta_o (obeta),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, obeta, ocol};

endmodule

@@ sv/olst_ram.sv @@
// generic single-port-write ram with registered read
// depends on olst_pkg for default sizes
module olst_ram import olst_pkg::*; #(
  parameter int Width = DataW,
  parameter int Depth = MaxColumns,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/olst_front.sv @@
// front end: accepts requests, classifies them and queues commands
// depends on olst_pkg
module olst_front import olst_pkg::*; #(
  parameter int MAX_COLUMNS = MaxColumns
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  output logic                in_rdy_o,
  input  logic [1:0]          req_type_i,
  input  logic [ColW-1:0]     col_i,
  input  logic [DataW-1:0]    u_i,
  input  logic [DataW-1:0]    y_i,
  input  logic [DataW-1:0]    d_i,
  output logic                head_vld_o,
  output cmd_t                head_o,
  input  logic                pop_i
);

  localparam int PtrW = $clog2(FifoDepth);

  cmd_t            fifo_q [FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            full, push, col_ok, accept;
  cmd_t            cmd;

  assign full     = (cnt_q == (PtrW+1)'(FifoDepth));
  assign in_rdy_o = !full;
  assign accept   = in_vld_i && !full;
  assign col_ok   = ({1'b0, col_i} < (ColW+1)'(MAX_COLUMNS));

  always_comb begin
    cmd.col  = col_i;
    cmd.op   = OP_ACC;
    cmd.data = {y_i, u_i};
    push     = 1'b0;
    case (req_type_i)
      OP_ACC: begin
        push = accept && col_ok;
      end
      OP_EIG: begin
        cmd.op   = OP_EIG;
        cmd.data = {{DataW{1'b0}}, d_i};
        push     = accept && col_ok;
      end
      OP_FIN: begin
        cmd.op = OP_FIN;
        push   = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd;
    end
  end

  assign head_vld_o = (cnt_q != '0);
  assign head_o     = fifo_q[rptr_q];

endmodule

@@ sv/olst_back.sv @@
// back end: accumulation, eigenvalue store and the finish walk with
// iterative square root and division; depends on olst_pkg, olst_ram, the defines header
`include "orthogonal_lasso_soft_threshold_unit_defines.svh"
module olst_back import olst_pkg::*; #(
  parameter int MAX_COLUMNS = MaxColumns
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              head_vld_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              out_vld_o,
  input  logic              out_rdy_i,
  output logic [ColW-1:0]   out_col_o,
  output logic [DataW-1:0]  out_beta_o,
  output logic              out_last_o
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int JW = $clog2(MAX_COLUMNS + 1);
  localparam int AccW = 2 * DataW;
  localparam int NumW = 88;

  bk_state_e st_q, st_d;

  logic [JW-1:0]         j_q, j_d, cols_q, cols_d;
  logic [48:0]           l_q, l_d;
  logic signed [AccW-1:0] prod_q, prod_d;
  logic [CW-1:0]         acol_q, acol_d;
  logic [MAX_COLUMNS-1:0] vld_q, vld_d;
  logic                  neg_q, neg_d;
  logic [AccW-1:0]       a_q, a_d;
  logic [47:0]           sv_q, sv_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [23:0]           s_q, s_d;
  logic [55:0]           pl_q, pl_d, ph_q, ph_d;
  logic [47:0]           den_q, den_d, rem_q, rem_d;
  logic [NumW-1:0]       num_q, num_d;
  logic [31:0]           quo_q, quo_d, beta_q, beta_d;
  logic                  ovf_q, ovf_d;
  logic [6:0]            cnt_q, cnt_d;

  logic                  ovld_q, ovld_d, olast_q, olast_d;
  logic [ColW-1:0]       ocol_q, ocol_d;
  logic [DataW-1:0]      obeta_q, obeta_d;

  logic                  acc_we, load, last;
  logic [CW-1:0]         acc_raddr;
  logic [AccW-1:0]       acc_wdata, acc_rdata, acc_old, acc_sum;
  logic                  eig_we;
  logic [DataW-1:0]      eig_rdata;
  logic [RowW-1:0]       nrows;
  logic [48:0]           sq_try;
  logic [48:0]           rem_sh;
  logic [NumW-1:0]       lw;
  logic [31:0]           cap, mag;

  olst_ram #(.Width(AccW), .Depth(MAX_COLUMNS)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acol_q),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  olst_ram #(.Width(DataW), .Depth(MAX_COLUMNS)) u_eig_ram (
    .clk_i   (clk_i),
    .we_i    (eig_we),
    .waddr_i (head_i.col[CW-1:0]),
    .wdata_i (head_i.data[DataW-1:0]),
    .raddr_i (j_q[CW-1:0]),
    .rdata_o (eig_rdata)
  );

  assign acc_raddr = (st_q == ST_IDLE) ? head_i.col[CW-1:0] : j_q[CW-1:0];
  assign lw        = {7'd0, l_q, 32'd0};
  assign nrows     = (cfg_i.row_count > RowW'(MaxRows)) ? RowW'(MaxRows) : cfg_i.row_count;
  assign last      = (JW'(j_q + 1'b1) == cols_q);

  always_comb begin
    st_d    = st_q;
    j_d     = j_q;
    cols_d  = cols_q;
    l_d     = l_q;
    prod_d  = prod_q;
    acol_d  = acol_q;
    vld_d   = vld_q;
    neg_d   = neg_q;
    a_d     = a_q;
    sv_d    = sv_q;
    sres_d  = sres_q;
    sbit_d  = sbit_q;
    s_d     = s_q;
    pl_d    = pl_q;
    ph_d    = ph_q;
    den_d   = den_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    beta_d  = beta_q;
    ovld_d  = ovld_q && !out_rdy_i;
    ocol_d  = ocol_q;
    obeta_d = obeta_q;
    olast_d = olast_q;
    pop_o   = 1'b0;
    acc_we  = 1'b0;
    eig_we  = 1'b0;
    load    = 1'b0;
    acc_old = vld_q[acol_q] ? acc_rdata : '0;
    acc_sum = acc_old + prod_q;
    acc_wdata = acc_sum;
    if (acc_old[AccW-1] == prod_q[AccW-1] && acc_sum[AccW-1] != acc_old[AccW-1]) begin
      acc_wdata = acc_old[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    sq_try = {1'b0, sres_q} + {1'b0, sbit_q};
    rem_sh = {rem_q, num_q[NumW-1]};
    cap    = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
    mag    = (ovf_q || quo_q > cap) ? cap : quo_q;
    case (st_q)
      ST_IDLE: begin
        if (head_vld_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_ACC: begin
              acol_d = head_i.col[CW-1:0];
              prod_d = $signed(head_i.data[DataW-1:0]) * $signed(head_i.data[AccW-1:DataW]);
              st_d   = ST_ACC;
            end
            OP_EIG: begin
              eig_we = 1'b1;
            end
            OP_FIN: begin
              cols_d = (cfg_i.column_count > CntW'(MAX_COLUMNS)) ? JW'(MAX_COLUMNS)
                                                                 : JW'(cfg_i.column_count);
              l_d    = cfg_i.lambda * nrows;
              j_d    = '0;
              if (cols_d == '0) begin
                vld_d = '0;
              end else begin
                st_d = ST_RD;
              end
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ACC: begin
        acc_we        = 1'b1;
        vld_d[acol_q] = 1'b1;
        st_d          = ST_IDLE;
      end
      ST_RD: begin
        st_d = ST_LOAD;
      end
      ST_LOAD: begin
        a_d    = vld_q[j_q[CW-1:0]] ? acc_rdata : '0;
        neg_d  = a_d[AccW-1];
        a_d    = neg_d ? (~a_d + 1'b1) : a_d;
        sv_d   = {eig_rdata, 16'd0};
        sres_d = '0;
        sbit_d = 48'd1 << 46;
        st_d   = ST_SQRT;
      end
      ST_SQRT: begin
        if ({1'b0, sv_q} >= sq_try) begin
          sv_d   = sv_q - sq_try[47:0];
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q[0]) begin
          s_d  = sres_d[23:0];
          st_d = ST_MUL0;
        end
      end
      ST_MUL0: begin
        if (s_q == '0) begin
          beta_d = '0;
          st_d   = ST_OUT;
        end else begin
          pl_d = a_q[31:0] * s_q;
          st_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        ph_d  = a_q[63:32] * s_q;
        den_d = s_q * s_q;
        st_d  = ST_SUM;
      end
      ST_SUM: begin
        num_d = {32'd0, pl_q} + {ph_q, 32'd0};
        st_d  = ST_CMP;
      end
      ST_CMP: begin
        if (num_q > lw) begin
          num_d = num_q - lw;
          rem_d = '0;
          quo_d = '0;
          ovf_d = 1'b0;
          cnt_d = '0;
          st_d  = ST_DIV;
        end else begin
          beta_d = '0;
          st_d   = ST_OUT;
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = 48'(rem_sh - {1'b0, den_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh[47:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        ovf_d = ovf_q | quo_q[31];
        num_d = num_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 7'(NumW - 1)) begin
          st_d = ST_FIX;
        end
      end
      ST_FIX: begin
        beta_d = neg_q ? (~mag + 1'b1) : mag;
        st_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_q || out_rdy_i) begin
          load    = 1'b1;
          ovld_d  = 1'b1;
          ocol_d  = ColW'(j_q);
          obeta_d = beta_q;
          olast_d = last;
          if (last) begin
            vld_d = '0;
            st_d  = ST_IDLE;
          end else begin
            j_d  = JW'(j_q + 1'b1);
            st_d = ST_RD;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      vld_q  <= vld_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    cols_q  <= cols_d;
    l_q     <= l_d;
    prod_q  <= prod_d;
    acol_q  <= acol_d;
    neg_q   <= neg_d;
    a_q     <= a_d;
    sv_q    <= sv_d;
    sres_q  <= sres_d;
    sbit_q  <= sbit_d;
    s_q     <= s_d;
    pl_q    <= pl_d;
    ph_q    <= ph_d;
    den_q   <= den_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    ovf_q   <= ovf_d;
    cnt_q   <= cnt_d;
    beta_q  <= beta_d;
    ocol_q  <= ocol_d;
    obeta_q <= obeta_d;
    olast_q <= olast_d;
  end

  assign out_vld_o  = ovld_q;
  assign out_col_o  = ocol_q;
  assign out_beta_o = obeta_q;
  assign out_last_o = olast_q;

  `OLST_ASSERT_IMP(a_div_nonzero, st_q == ST_DIV, den_q != '0, "divide by zero")
  `OLST_ASSERT_IMP(a_pop_valid, pop_o, head_vld_i, "pop from empty queue")
  `OLST_ASSERT_NXT(a_clear_on_last, load && last, vld_q == '0, "accumulators not cleared")

endmodule

@@ tb/tb_top.sv @@
// testbench for the lasso soft threshold unit: random and directed requests,
// an in-bench predictor of the coefficients, a scoreboard on the result stream
// depends on olst_pkg and orthogonal_lasso_soft_threshold_unit
module tb_top;
  import olst_pkg::*;

  localparam logic [1:0] ReqBad = 2'd3;

  typedef struct {
    logic [5:0]  col;
    logic [31:0] beta;
    logic        last;
  } coef_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata = '0;  // col_index, u_value, y_value, d_value
  logic [1:0]    s_axis_tuser = '0;  // req_type
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [39:0]   m_axis_tdata;       // col_index_out, beta
  logic          m_axis_tlast;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = '0;
  logic [31:0]   cfg_wdata_i = '0;

  logic signed [63:0] col_acc [64];
  logic [31:0]        eig_val [64];
  logic [31:0]        lam_reg = '0;
  logic [16:0]        rows_reg = 17'd1;
  logic [6:0]         cols_reg = 7'd64;

  coef_t expected_coefs[$];
  int    errors = 0;
  bit    quiet = 1'b0;
  int    hold_cycles = 0;
  int    rx_wait = 0;

  orthogonal_lasso_soft_threshold_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [23:0] root_q16(logic [31:0] d);
    logic [47:0] v, res, b;
    v = {d, 16'h0};
    res = '0;
    b = 48'h1 << 46;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[23:0];
  endfunction

  function automatic logic [31:0] shrink(logic signed [63:0] acc, logic [31:0] d);
    logic [127:0] a, s, prod, lw, q, cap;
    logic [63:0]  mg;
    logic [16:0]  n;
    logic         neg;
    s = 128'(root_q16(d));
    if (s == 0) return '0;
    neg = acc < 0;
    mg = neg ? 64'd0 - acc : acc;
    a = 128'(mg);
    n = (rows_reg > 17'd65536) ? 17'd65536 : rows_reg;
    lw = (128'(lam_reg) * 128'(n)) << 32;
    prod = a * s;
    if (prod <= lw) return '0;
    q = (prod - lw) / (s * s);
    cap = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > cap) q = cap;
    return neg ? 32'(128'd0 - q) : q[31:0];
  endfunction

  task automatic predict(logic [1:0] kind, logic [5:0] col, logic [31:0] u,
                         logic [31:0] y, logic [31:0] d);
    logic signed [63:0] p, sum;
    int cols;
    coef_t c;
    if (kind == OP_ACC) begin
      p = $signed(u) * $signed(y);
      sum = col_acc[col] + p;
      if (col_acc[col] >= 0 && p >= 0 && sum < 0) sum = 64'h7fff_ffff_ffff_ffff;
      else if (col_acc[col] < 0 && p < 0 && sum >= 0) sum = 64'h8000_0000_0000_0000;
      col_acc[col] = sum;
    end else if (kind == OP_EIG) begin
      eig_val[col] = d;
    end else if (kind == OP_FIN) begin
      cols = (cols_reg > 7'd64) ? 64 : int'(cols_reg);
      for (int j = 0; j < cols; j++) begin
        c.col = 6'(j);
        c.beta = shrink(col_acc[j], eig_val[j]);
        c.last = (j + 1 == cols);
        expected_coefs.push_back(c);
      end
      for (int j = 0; j < 64; j++) col_acc[j] = '0;
    end
  endtask

  task automatic send_req(logic [1:0] kind, logic [5:0] col, logic [31:0] u,
                          logic [31:0] y, logic [31:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {2'b00, d, y, u, col};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(kind, col, u, y, d);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_coefs.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [31:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LAMBDA: lam_reg = val;
      CFG_ROWS:   rows_reg = val[16:0];
      CFG_COLS:   cols_reg = val[6:0];
      default:    ;
    endcase
  endtask

  function automatic logic [31:0] rand_val();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    int wait_n;
    wait_n = rx_wait;
    if (m_axis_tvalid && m_axis_tready) wait_n = quiet ? 0 : $urandom_range(0, 9);
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (wait_n > 0) begin
      m_axis_tready <= 1'b0;
      wait_n = wait_n - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
    rx_wait <= wait_n;
  end

  always @(posedge clk_i) begin
    coef_t c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_coefs.size() == 0) begin
        report_mismatch("unexpected coefficient", 32'(m_axis_tdata[37:6]), '0);
      end else begin
        c = expected_coefs.pop_front();
        if (m_axis_tdata[5:0] != c.col) report_mismatch("column", 32'(m_axis_tdata[5:0]), 32'(c.col));
        if (m_axis_tdata[37:6] != c.beta) report_mismatch("beta", m_axis_tdata[37:6], c.beta);
        if (m_axis_tlast != c.last) report_mismatch("last", 32'(m_axis_tlast), 32'(c.last));
      end
    end
  end

  // every eigenvalue written before any finish
  task automatic test_eigen_load();
    logic [31:0] d;
    for (int j = 0; j < 64; j++) begin
      case (j)
        3:       d = '0;
        4:       d = 32'hffff_ffff;
        5:       d = 32'h1;
        default: d = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000);
      endcase
      send_req(OP_EIG, 6'(j), '0, '0, d);
    end
  endtask

  task automatic test_extremes();
    send_req(OP_ACC, 6'd0, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    send_req(OP_ACC, 6'd0, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    send_req(OP_ACC, 6'd0, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    send_req(OP_ACC, 6'd1, 32'h8000_0000, 32'h7fff_ffff, '0);
    send_req(OP_ACC, 6'd1, 32'h8000_0000, 32'h7fff_ffff, '0);
    send_req(OP_ACC, 6'd1, 32'h8000_0000, 32'h7fff_ffff, '0);
    send_req(OP_ACC, 6'd2, 32'h8000_0000, 32'h8000_0000, '0);
    send_req(OP_ACC, 6'd3, 32'h0001_0000, 32'h0005_0000, '0);
    send_req(OP_ACC, 6'd4, 32'hffff_0000, 32'h0003_0000, '0);
    send_req(OP_ACC, 6'd5, 32'h0000_0001, 32'hffff_ffff, '0);
    send_req(OP_ACC, 6'd63, 32'h0002_0000, 32'h0002_0000, '0);
    send_req(ReqBad, 6'd7, $urandom, $urandom, $urandom);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
    cfg_write(CFG_LAMBDA, 32'h0001_0000);
    send_req(OP_ACC, 6'd6, 32'h0010_0000, 32'h0010_0000, '0);
    send_req(OP_ACC, 6'd7, 32'hfff0_0000, 32'h0010_0000, '0);
    send_req(OP_ACC, 6'd8, 32'h0000_0100, 32'h0000_0100, '0);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
  endtask

  task automatic test_config_corners();
    cfg_write(CFG_LAMBDA, 32'hffff_ffff);
    cfg_write(CFG_ROWS, 32'h0001_ffff);
    cfg_write(CFG_COLS, 32'h7f);
    send_req(OP_ACC, 6'd9, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
    cfg_write(CFG_ROWS, '0);
    cfg_write(CFG_LAMBDA, 32'h0000_8000);
    cfg_write(CFG_COLS, '0);
    send_req(OP_ACC, 6'd0, 32'h0003_0000, 32'h0003_0000, '0);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
    cfg_write(CFG_COLS, 32'd1);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
    cfg_write(CFG_ROWS, 32'd65536);
    cfg_write(CFG_COLS, 32'd64);
    send_req(OP_ACC, 6'd40, 32'h0100_0000, 32'h0100_0000, '0);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
  endtask

  task automatic test_random();
    int cols;
    int pick;
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      cfg_write(CFG_LAMBDA, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0000_4000));
      cfg_write(CFG_ROWS, (ph == 4) ? 32'd65536 : $urandom_range(1, 16));
      cols = (ph == 1) ? 64 : $urandom_range(1, 8);
      cfg_write(CFG_COLS, 32'(cols));
      for (int i = 0; i < 6; i++) begin
        pick = $urandom_range(0, 99);
        if (i == 5 || pick < 8) send_req(OP_FIN, 6'($urandom), $urandom, $urandom, $urandom);
        else if (pick < 16) send_req(OP_EIG, 6'($urandom), $urandom, $urandom, $urandom);
        else if (pick < 20) send_req(ReqBad, 6'($urandom), $urandom, $urandom, $urandom);
        else if (pick < 28) send_req(OP_ACC, 6'($urandom), rand_val(), rand_val(), $urandom);
        else send_req(OP_ACC, 6'($urandom_range(0, cols - 1)), rand_val(), rand_val(), $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    cfg_write(CFG_COLS, 32'd8);
    @(negedge clk_i);
    hold_cycles = 1500;
    @(posedge clk_i);
    send_req(OP_ACC, 6'd1, rand_val(), rand_val(), '0);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
    for (int i = 0; i < 10; i++) send_req(OP_ACC, 6'($urandom_range(0, 7)), rand_val(), rand_val(), '0);
    send_req(OP_FIN, 6'd0, '0, '0, '0);
  endtask

  initial begin
    for (int j = 0; j < 64; j++) begin
      col_acc[j] = '0;
      eig_val[j] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_eigen_load();
    test_extremes();
    test_config_corners();
    test_random();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("orthogonal_lasso_soft_threshold_unit test passed");
    end else begin
      $display("orthogonal_lasso_soft_threshold_unit test failed");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("orthogonal_lasso_soft_threshold_unit test failed");
    $finish;
  end

endmodule
